FILE: hdl/sbpr_pkg.sv
// Package: shared types, codes and the CRC byte update for the servo bus packet receiver.
`timescale 1ns / 1ps

package sbpr_pkg;

    // Header bytes and fixed offsets within a packet
    localparam logic [7:0] HDR_BYTE0 = 8'hFF;
    localparam logic [7:0] HDR_BYTE1 = 8'hFF;
    localparam logic [7:0] HDR_BYTE2 = 8'hFD;
    localparam logic [7:0] HDR_BYTE3 = 8'h00;

    localparam int OFS_HDR0      = 0;
    localparam int OFS_HDR1      = 1;
    localparam int OFS_HDR2      = 2;
    localparam int OFS_HDR3      = 3;
    localparam int OFS_LEN_L     = 5;
    localparam int OFS_LEN_H     = 6;
    localparam int OFS_PARAM0    = 8;
    localparam int OFS_CRC_LO    = 5;  // CRC_L sits at LEN + 5
    localparam int OFS_CRC_HI    = 6;  // CRC_H sits at LEN + 6
    localparam int MIN_LENGTH    = 3;

    localparam logic [15:0] CRC_POLY = 16'h8005;

    // Result error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_FORMAT   = 2'd1;
    localparam logic [1:0] ERR_CRC      = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // Byte class decided by the front end
    typedef enum logic [2:0] {
        K_PLAIN  = 3'd0,
        K_PARAM  = 3'd1,
        K_CRC_LO = 3'd2,
        K_CRC_HI = 3'd3,
        K_FORMAT = 3'd4
    } t_kind;

    // One classified byte travelling from front to back
    typedef struct packed {
        logic [7:0] rx_byte;
        logic [7:0] position;
        t_kind      kind;
        logic       crc_match;
        logic       at_limit;
    } t_item;

    // CRC-16, MSB first, one byte per call
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/sbpr_front.sv
// Front end: tracks packet offset, length and CRC, and classifies each byte.
`timescale 1ns / 1ps

module sbpr_front #(
    parameter int MAX_PACKET_BYTES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_rx_byte,
    output sbpr_pkg::t_item o_item
);

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES);

    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_len, n_len;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_crc_lo, n_crc_lo;

    sbpr_pkg::t_kind  kind;
    logic [15:0]      len_next;
    logic [16:0]      pos_wide;
    logic [16:0]      len_wide;
    logic             hdr_bad;
    logic             crc_match;
    logic             at_limit;
    logic             restart;

    always_comb begin
        pos_wide  = 17'(r_count);
        len_wide  = 17'(r_len);
        len_next  = r_len;
        crc_match = (r_crc == {i_rx_byte, r_crc_lo});
        at_limit  = (r_count == CNT_W'(MAX_PACKET_BYTES - 1));
        hdr_bad   = ((r_count == CNT_W'(sbpr_pkg::OFS_HDR0)) && (i_rx_byte != sbpr_pkg::HDR_BYTE0))
                 || ((r_count == CNT_W'(sbpr_pkg::OFS_HDR1)) && (i_rx_byte != sbpr_pkg::HDR_BYTE1))
                 || ((r_count == CNT_W'(sbpr_pkg::OFS_HDR2)) && (i_rx_byte != sbpr_pkg::HDR_BYTE2))
                 || ((r_count == CNT_W'(sbpr_pkg::OFS_HDR3)) && (i_rx_byte != sbpr_pkg::HDR_BYTE3));
        kind      = sbpr_pkg::K_PLAIN;

        if (hdr_bad) begin
            kind = sbpr_pkg::K_FORMAT;
        end else if (r_count == CNT_W'(sbpr_pkg::OFS_LEN_L)) begin
            len_next = {8'h00, i_rx_byte};
        end else if (r_count == CNT_W'(sbpr_pkg::OFS_LEN_H)) begin
            len_next = {i_rx_byte, r_len[7:0]};
            if (len_next < 16'(sbpr_pkg::MIN_LENGTH)) begin
                kind = sbpr_pkg::K_FORMAT;
            end
        end else if (pos_wide >= 17'(sbpr_pkg::OFS_PARAM0)) begin
            if (pos_wide < len_wide + 17'(sbpr_pkg::OFS_CRC_LO)) begin
                kind = sbpr_pkg::K_PARAM;
            end else if (pos_wide == len_wide + 17'(sbpr_pkg::OFS_CRC_LO)) begin
                kind = sbpr_pkg::K_CRC_LO;
            end else if (pos_wide == len_wide + 17'(sbpr_pkg::OFS_CRC_HI)) begin
                kind = sbpr_pkg::K_CRC_HI;
            end else begin
                kind = sbpr_pkg::K_FORMAT;
            end
        end

        restart = (kind == sbpr_pkg::K_FORMAT) || (kind == sbpr_pkg::K_CRC_HI) || at_limit;

        n_count  = r_count;
        n_len    = r_len;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        if (i_accept) begin
            if (restart) begin
                n_count  = '0;
                n_len    = '0;
                n_crc    = '0;
                n_crc_lo = '0;
            end else begin
                n_count = r_count + CNT_W'(1);
                n_len   = len_next;
                if (kind == sbpr_pkg::K_CRC_LO) begin
                    n_crc_lo = i_rx_byte;
                end else begin
                    n_crc = sbpr_pkg::crc_feed(r_crc, i_rx_byte);
                end
            end
        end

        o_item.rx_byte   = i_rx_byte;
        o_item.position  = 8'(r_count);
        o_item.kind      = kind;
        o_item.crc_match = crc_match;
        o_item.at_limit  = at_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_len    <= '0;
            r_crc    <= '0;
            r_crc_lo <= '0;
        end else begin
            r_count  <= n_count;
            r_len    <= n_len;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

endmodule

FILE: hdl/sbpr_queue.sv
// Short queue of classified bytes between the front end and the result stage.
`timescale 1ns / 1ps

module sbpr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sbpr_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output sbpr_pkg::t_item o_item
);

    localparam int PTR_W = (sbpr_pkg::Q_DEPTH > 1) ? $clog2(sbpr_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(sbpr_pkg::Q_DEPTH + 1);

    sbpr_pkg::t_item  r_mem [sbpr_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full     = (r_count == CNT_W'(sbpr_pkg::Q_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(sbpr_pkg::Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(sbpr_pkg::Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: hdl/sbpr_back.sv
// Result stage: resolves flags and error code and holds the output transaction.
`timescale 1ns / 1ps

module sbpr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_nonempty,
    input  sbpr_pkg::t_item i_item,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [7:0]      o_echo_byte,
    output logic [7:0]      o_byte_position,
    output logic            o_is_parameter,
    output logic            o_packet_done,
    output logic [1:0]      o_error_code
);

    logic       r_valid;
    logic [7:0] r_echo, r_pos;
    logic       r_param, r_done;
    logic [1:0] r_err;

    logic [1:0] err;
    logic       done;
    logic       param;

    always_comb begin
        done = 1'b0;
        unique case (i_item.kind)
            sbpr_pkg::K_FORMAT: begin
                err = sbpr_pkg::ERR_FORMAT;
            end
            sbpr_pkg::K_CRC_HI: begin
                done = i_item.crc_match;
                err  = i_item.crc_match ? sbpr_pkg::ERR_NONE : sbpr_pkg::ERR_CRC;
            end
            default: begin
                err = i_item.at_limit ? sbpr_pkg::ERR_OVERFLOW : sbpr_pkg::ERR_NONE;
            end
        endcase
        param = (i_item.kind == sbpr_pkg::K_PARAM) && (err == sbpr_pkg::ERR_NONE);
    end

    // Load a new transaction when the register is empty or being taken
    assign o_pop = i_nonempty && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_echo  <= i_item.rx_byte;
            r_pos   <= i_item.position;
            r_param <= param;
            r_done  <= done;
            r_err   <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid         = r_valid;
    assign o_echo_byte     = r_echo;
    assign o_byte_position = r_pos;
    assign o_is_parameter  = r_param;
    assign o_packet_done   = r_done;
    assign o_error_code    = r_err;

endmodule

FILE: hdl/servo_bus_packet_receiver_core.sv
// Top level: servo bus command packet receiver with CRC-16 check.
// An accepted byte is written into the queue and from there loaded into the output register.
// Throughput: one byte per cycle while the queue is not full; the front end updates the CRC a byte at a time.
// A 2-entry queue plus the output register absorb output stalls; the input is stalled while the queue is full.
// Reset (synchronous, active low) clears offset, length, CRC state, queue and output valid.
`timescale 1ns / 1ps

module servo_bus_packet_receiver_core #(
    parameter int MAX_PACKET_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Received byte channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    // Result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_echo_byte,
    output logic [7:0] o_byte_position,
    output logic       o_is_parameter,
    output logic       o_packet_done,
    output logic [1:0] o_error_code
);

    sbpr_pkg::t_item front_item;
    sbpr_pkg::t_item queue_item;
    logic            accept;
    logic            q_full;
    logic            q_nonempty;
    logic            pop;

    // Hold off the serial side only while the queue is full
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    // Front end: advance packet offset, length and CRC on every accepted transaction
    sbpr_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_item    (front_item)
    );

    // Queue: decouple the front end from output back-pressure
    sbpr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_item     (front_item),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_item     (queue_item)
    );

    // Back end: resolve done / error and register the outgoing transaction
    sbpr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_nonempty      (q_nonempty),
        .i_item          (queue_item),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_echo_byte     (o_echo_byte),
        .o_byte_position (o_byte_position),
        .o_is_parameter  (o_is_parameter),
        .o_packet_done   (o_packet_done),
        .o_error_code    (o_error_code)
    );

endmodule

FILE: hdl/sbpr_checker.sv
// Checker: port-level properties of the packet receiver, bound to the top level.
`timescale 1ns / 1ps

module sbpr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_echo_byte,
    input logic [7:0] o_byte_position,
    input logic       o_is_parameter,
    input logic       o_packet_done,
    input logic [1:0] o_error_code
);

    // A completed packet never carries an error
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_packet_done) |-> (o_error_code == sbpr_pkg::ERR_NONE))
        else $error("packet_done with nonzero error code");

    // Parameter mark only on error-free bytes
    a_param_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_parameter) |-> (o_error_code == sbpr_pkg::ERR_NONE))
        else $error("parameter mark on errored byte");

    // A packet that completes restarts the offset at zero
    a_restart_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_packet_done) ##1 o_valid |-> (o_byte_position == 8'd0))
        else $error("offset did not restart after packet_done");

    // A stalled output transaction holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_echo_byte) && $stable(o_error_code)))
        else $error("stalled output changed");

endmodule

bind servo_bus_packet_receiver_core sbpr_checker u_sbpr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_echo_byte     (o_echo_byte),
    .o_byte_position (o_byte_position),
    .o_is_parameter  (o_is_parameter),
    .o_packet_done   (o_packet_done),
    .o_error_code    (o_error_code)
);
